// ===== src/rotary_encoder_with_button_defines.svh =====
// assertion macros for the rotary encoder block
// uses the clk and rst names of the module that expands them
`ifndef ROTARY_ENCODER_WITH_BUTTON_DEFINES_SVH
`define ROTARY_ENCODER_WITH_BUTTON_DEFINES_SVH
`ifndef SYNTH
`define RTEB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rteb assertion failed");
`define RTEB_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rteb assertion failed");
`else
`define RTEB_ASSERT(label, prop)
`define RTEB_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ===== src/rteb_pkg.sv =====
// shared types, codes and the gray step table for the rotary encoder block
// no dependencies
package rteb_pkg;

  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_PPD       = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd2;
  localparam logic [1:0] CFG_LONG      = 2'd3;

  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [3:0]  PPD_RESET      = 4'd4;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [15:0] LONG_RESET     = 16'd1000;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_CW,
    STEP_CCW
  } step_t;

  typedef struct packed {
    logic        chan_a;
    logic        chan_b;
    logic        button_level;
    logic [31:0] time_ms;
    logic        take_direction;
    logic        take_click;
    logic        take_long;
    logic        zero_position;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [1:0]         direction;
    logic               clicked;
    logic               long_press;
    logic               pressed;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [1:0]         direction;
  } quad_stat_t;

  typedef struct packed {
    logic clicked;
    logic long_press;
    logic pressed;
  } btn_stat_t;

  function automatic step_t gray_step(input logic [3:0] code);
    step_t s;
    unique case (code)
      4'b0001, 4'b0111, 4'b1110, 4'b1000: s = STEP_CW;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: s = STEP_CCW;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== src/rteb_quad.sv =====
// quadrature decoder: step counter, detent position and sticky direction
// depends on rteb_pkg and the block's assertion macros
`include "rotary_encoder_with_button_defines.svh"
module rteb_quad
  import rteb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       enable,
  input  logic [1:0] ab,
  input  logic [3:0] ppd,
  input  logic       take_direction,
  input  logic       zero_position,
  output quad_stat_t stat
);

  logic [1:0]         last_ab;
  logic signed [4:0]  step_count;
  logic signed [31:0] position_count;
  logic [1:0]         dir_hold;

  logic [1:0]         last_ab_next;
  logic signed [4:0]  step_count_next;
  logic signed [31:0] pos_upd;
  logic [1:0]         dir_upd;
  logic signed [4:0]  limit;
  logic signed [4:0]  step_sum;
  step_t              st;
  logic               moved;

  always_comb begin
    moved           = enable && (ab != last_ab);
    st              = gray_step({last_ab, ab});
    limit           = $signed({1'b0, (ppd == 4'd0) ? 4'd1 : ppd});
    step_sum        = (st == STEP_CW) ? step_count + 5'sd1 : step_count - 5'sd1;
    last_ab_next    = moved ? ab : last_ab;
    step_count_next = step_count;
    pos_upd         = position_count;
    dir_upd         = dir_hold;
    if (moved && st != STEP_NONE) begin
      if (step_sum >= limit) begin
        step_count_next = 5'sd0;
        pos_upd         = position_count + 32'sd1;
        dir_upd         = DIR_CW;
      end else if (step_sum <= -limit) begin
        step_count_next = 5'sd0;
        pos_upd         = position_count - 32'sd1;
        dir_upd         = DIR_CCW;
      end else begin
        step_count_next = step_sum;
      end
    end
  end

  assign stat.position  = pos_upd;
  assign stat.direction = dir_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ab        <= 2'b00;
      step_count     <= 5'sd0;
      position_count <= 32'sd0;
      dir_hold       <= DIR_NONE;
    end else if (fire) begin
      last_ab        <= last_ab_next;
      step_count     <= step_count_next;
      position_count <= zero_position ? 32'sd0 : pos_upd;
      dir_hold       <= take_direction ? DIR_NONE : dir_upd;
    end
  end

  `RTEB_ASSERT_NEXT(a_quad_idle_ab, !fire, $stable(last_ab))
  `RTEB_ASSERT_NEXT(a_quad_disabled, fire && !enable, $stable(last_ab) && $stable(step_count))
  `RTEB_ASSERT(a_quad_dir_code, dir_hold == DIR_NONE || dir_hold == DIR_CW || dir_hold == DIR_CCW)

endmodule

// ===== src/rteb_button.sv =====
// button press timer: debounce, click and long-press flags
// depends on rteb_pkg and the block's assertion macros
`include "rotary_encoder_with_button_defines.svh"
module rteb_button
  import rteb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        enable,
  input  logic        button_level,
  input  logic [31:0] time_ms,
  input  logic [15:0] debounce_ms,
  input  logic [15:0] long_press_ms,
  input  logic        take_click,
  input  logic        take_long,
  output btn_stat_t   stat
);

  logic        held;
  logic [31:0] press_start;
  logic        click_flag;
  logic        long_flag;

  logic        held_next;
  logic        click_upd;
  logic        long_upd;
  logic        down;
  logic        start_press;
  logic [31:0] length;

  always_comb begin
    down        = !button_level;
    start_press = enable && down && !held;
    length      = time_ms - press_start;
    held_next   = held;
    click_upd   = click_flag;
    long_upd    = long_flag;
    if (start_press) begin
      held_next = 1'b1;
    end else if (enable && !down && held) begin
      held_next = 1'b0;
      if (length >= {16'd0, debounce_ms}) begin
        if (length >= {16'd0, long_press_ms}) begin
          long_upd = 1'b1;
        end else begin
          click_upd = 1'b1;
        end
      end
    end
  end

  assign stat.clicked    = click_upd;
  assign stat.long_press = long_upd;
  assign stat.pressed    = held_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= 1'b0;
      press_start <= 32'd0;
      click_flag  <= 1'b0;
      long_flag   <= 1'b0;
    end else if (fire) begin
      held       <= held_next;
      click_flag <= take_click ? 1'b0 : click_upd;
      long_flag  <= take_long ? 1'b0 : long_upd;
      if (start_press) begin
        press_start <= time_ms;
      end
    end
  end

  `RTEB_ASSERT_NEXT(a_btn_idle_held, !fire, $stable(held) && $stable(click_flag))
  `RTEB_ASSERT_NEXT(a_btn_disabled, fire && !enable, $stable(held) && $stable(press_start))
  `RTEB_ASSERT_NEXT(a_btn_take_click, fire && take_click, !click_flag)

endmodule

// ===== src/rotary_encoder_with_button.sv =====
// rotary encoder with push button: top level, config registers and beat pipeline
// depends on rteb_pkg, rteb_quad, rteb_button and the block's assertion macros
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one sample beat: channel levels,
//   active-low button level, millisecond time and the take/zero request bits.
//   out channel (out_valid/out_ready/out_data) returns exactly one beat per sample:
//   position, sticky direction, click and long-press flags and the pressed level.
//   config port: cfg_write with cfg_index/cfg_data writes a register (0 enable,
//   1 pulses per detent, 2 debounce ms, 3 long press ms); write only
//   while no beat is in flight.
//   path: an accepted sample is latched in the input register, then processed and
//   registered into out_data with out_valid once the result register is free to
//   take it; a stalled receiver delays that step.
//   throughput: one beat per cycle unless out_ready stalls; single state update stage.
//   reset: state but hold/out data clears, enable drops, detent 4, debounce 50, long press 1000.
//   a stalled receiver holds the result register; the input register still fills
//   once, after which in_ready drops until the result is taken.
`include "rotary_encoder_with_button_defines.svh"
module rotary_encoder_with_button
  import rteb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        enable;
  logic [3:0]  ppd;
  logic [15:0] debounce_ms;
  logic [15:0] long_press_ms;

  logic        hold_valid;
  in_beat_t    hold_data;
  logic        fire;
  quad_stat_t  quad_stat;
  btn_stat_t   btn_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      ppd           <= PPD_RESET;
      debounce_ms   <= DEBOUNCE_RESET;
      long_press_ms <= LONG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ENABLE:   enable        <= cfg_data[0];
        CFG_PPD:      ppd           <= cfg_data[3:0];
        CFG_DEBOUNCE: debounce_ms   <= cfg_data[15:0];
        CFG_LONG:     long_press_ms <= cfg_data[15:0];
        default:      ;
      endcase
    end
  end

  assign fire     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
  end

  rteb_quad u_quad (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .enable         (enable),
    .ab             ({hold_data.chan_a, hold_data.chan_b}),
    .ppd            (ppd),
    .take_direction (hold_data.take_direction),
    .zero_position  (hold_data.zero_position),
    .stat           (quad_stat)
  );

  rteb_button u_button (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .enable        (enable),
    .button_level  (hold_data.button_level),
    .time_ms       (hold_data.time_ms),
    .debounce_ms   (debounce_ms),
    .long_press_ms (long_press_ms),
    .take_click    (hold_data.take_click),
    .take_long     (hold_data.take_long),
    .stat          (btn_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.position   <= quad_stat.position;
      out_data.direction  <= quad_stat.direction;
      out_data.clicked    <= btn_stat.clicked;
      out_data.long_press <= btn_stat.long_press;
      out_data.pressed    <= btn_stat.pressed;
    end
  end

  `RTEB_ASSERT_NEXT(a_top_fire_out, fire, out_valid)
  `RTEB_ASSERT_NEXT(a_top_hold_keep, hold_valid && !fire, hold_valid && $stable(hold_data))
  `RTEB_ASSERT(a_top_no_overrun, (out_valid && !out_ready) |-> !fire)

endmodule

// ===== bench/tb_rotary_encoder_with_button.sv =====
// self-checking bench for rotary_encoder_with_button: directed then random sample beats,
// with the expected status of each beat worked out by a scoreboard class
// depends on rteb_pkg and the rotary_encoder_with_button rtl
module tb_rotary_encoder_with_button;
  import rteb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class rteb_status_model;
    logic        en;
    logic [3:0]  ppd;
    logic [15:0] deb;
    logic [15:0] lng;
    logic [1:0]  ab;
    int          steps;
    logic [31:0] pos;
    logic [1:0]  dir;
    logic        held;
    logic [31:0] press_t;
    logic        click;
    logic        longf;
    out_beat_t   status_q[$];
    int          mismatches;

    function new();
      en = 1'b0;
      ppd = PPD_RESET;
      deb = DEBOUNCE_RESET;
      lng = LONG_RESET;
      ab = 2'b00;
      steps = 0;
      pos = '0;
      dir = DIR_NONE;
      held = 1'b0;
      press_t = '0;
      click = 1'b0;
      longf = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_ENABLE:   en = val[0];
        CFG_PPD:      ppd = val[3:0];
        CFG_DEBOUNCE: deb = val;
        CFG_LONG:     lng = val;
        default: ;
      endcase
    endfunction

    function void note_sample(in_beat_t s);
      logic [1:0]  nab;
      logic [31:0] span;
      int          lim;
      out_beat_t   r;
      nab = {s.chan_a, s.chan_b};
      lim = (ppd == 4'd0) ? 1 : int'(ppd);
      if (en) begin
        if (nab != ab) begin
          // a single flipped bit is a gray step, clockwise when new b differs from old a
          if (^(nab ^ ab)) begin
            steps += (nab[0] != ab[1]) ? 1 : -1;
            if (steps >= lim) begin
              pos = pos + 32'd1;
              dir = DIR_CW;
              steps = 0;
            end else if (steps <= -lim) begin
              pos = pos - 32'd1;
              dir = DIR_CCW;
              steps = 0;
            end
          end
          ab = nab;
        end
        if (!s.button_level && !held) begin
          held = 1'b1;
          press_t = s.time_ms;
        end else if (s.button_level && held) begin
          held = 1'b0;
          span = s.time_ms - press_t;
          if (span >= 32'(deb)) begin
            if (span >= 32'(lng)) longf = 1'b1;
            else click = 1'b1;
          end
        end
      end
      r.position = pos;
      r.direction = dir;
      r.clicked = click;
      r.long_press = longf;
      r.pressed = held;
      status_q.push_back(r);
      if (s.take_direction) dir = DIR_NONE;
      if (s.take_click) click = 1'b0;
      if (s.take_long) longf = 1'b0;
      if (s.zero_position) pos = '0;
    endfunction

    function void miss(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("status mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_status(out_beat_t got);
      out_beat_t want;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status beat with no sample pending: position %0d", got.position);
        return;
      end
      want = status_q.pop_front();
      if (got.position !== want.position) miss("position", want.position, got.position);
      if (got.direction !== want.direction) miss("direction", want.direction, got.direction);
      if (got.clicked !== want.clicked) miss("clicked", want.clicked, got.clicked);
      if (got.long_press !== want.long_press) miss("long_press", want.long_press, got.long_press);
      if (got.pressed !== want.pressed) miss("pressed", want.pressed, got.pressed);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_write;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rteb_status_model sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  logic [1:0]  gen_ab;
  logic        gen_lvl;
  logic        gen_cw;
  logic [31:0] gen_now;
  logic [31:0] gen_press_t;

  rotary_encoder_with_button u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver, with long hold-offs on request to back the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_served + 1;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_status(out_data);
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input in_beat_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(input logic en, input logic [3:0] ppd,
                               input logic [15:0] deb, input logic [15:0] lng);
    logic [1:0]  regs [4];
    logic [15:0] vals [4];
    regs = '{CFG_ENABLE, CFG_PPD, CFG_DEBOUNCE, CFG_LONG};
    vals = '{16'(en), 16'(ppd), deb, lng};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic in_beat_t mk(logic a, logic b, logic lvl, logic [31:0] t,
                                  logic td = 0, logic tc = 0, logic tl = 0, logic zp = 0);
    in_beat_t s;
    s.chan_a = a;
    s.chan_b = b;
    s.button_level = lvl;
    s.time_ms = t;
    s.take_direction = td;
    s.take_click = tc;
    s.take_long = tl;
    s.zero_position = zp;
    return s;
  endfunction

  // mostly clean rotation runs and timed presses, some noise
  task automatic make_sample(output in_beat_t s);
    int          pick;
    logic [31:0] span;
    pick = $urandom_range(0, 99);
    gen_now = gen_now + $urandom_range(0, 30);
    if (pick < 55) begin
      if ($urandom_range(0, 19) == 0) gen_cw = !gen_cw;
      gen_ab = gen_cw ? {gen_ab[0], ~gen_ab[1]} : {~gen_ab[0], gen_ab[1]};
    end else if (pick < 80) begin
      if (gen_lvl) begin
        gen_lvl = 1'b0;
        gen_press_t = gen_now;
      end else begin
        gen_lvl = 1'b1;
        case ($urandom_range(0, 6))
          0: span = (sb.deb > 0) ? $urandom_range(0, int'(sb.deb) - 1) : 0;
          1: span = 32'(sb.deb);
          2: span = 32'(sb.deb) + $urandom_range(0, 200);
          3: span = 32'(sb.lng);
          4: span = (sb.lng > 0) ? 32'(sb.lng) - 1 : 0;
          5: span = 32'(sb.lng) + $urandom_range(0, 2000);
          default: span = $urandom();
        endcase
        gen_now = gen_press_t + span;
      end
    end else if (pick >= 90) begin
      gen_ab = 2'($urandom_range(0, 3));
      gen_lvl = 1'($urandom_range(0, 1));
      gen_now = $urandom();
    end
    s.chan_a = gen_ab[1];
    s.chan_b = gen_ab[0];
    s.button_level = gen_lvl;
    s.time_ms = gen_now;
    s.take_direction = ($urandom_range(0, 99) < 15);
    s.take_click = ($urandom_range(0, 99) < 15);
    s.take_long = ($urandom_range(0, 99) < 15);
    s.zero_position = ($urandom_range(0, 99) < 5);
  endtask

  task automatic run_phase(input logic en, input logic [3:0] ppd, input logic [15:0] deb,
                           input logic [15:0] lng, input int sidle, input int rstall,
                           input int n, input bit hold, input logic [31:0] t0);
    in_beat_t s;
    drain();
    apply_setting(en, ppd, deb, lng);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (hold) hold_asked = hold_asked + 1;
    gen_ab = sb.ab;
    gen_lvl = !sb.held;
    gen_press_t = sb.press_t;
    gen_now = t0;
    repeat (n) begin
      make_sample(s);
      send_beat(s);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data = '0;
    gen_cw = 1'b1;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // disabled after reset: samples ignored, takes still act
    send_beat(mk(1, 1, 0, 32'd5, 1, 1, 1, 1));
    send_beat(mk(0, 1, 1, 32'hFFFF_FFFF));
    drain();

    apply_setting(1'b1, 4'd2, 16'd10, 16'd100);
    send_beat(mk(0, 1, 1, 32'd0));
    send_beat(mk(1, 1, 1, 32'd1));
    send_beat(mk(1, 1, 1, 32'd2));
    send_beat(mk(0, 0, 1, 32'd3));
    send_beat(mk(1, 0, 1, 32'd4));
    send_beat(mk(0, 0, 1, 32'd5));
    send_beat(mk(1, 0, 1, 32'd6));
    send_beat(mk(1, 1, 1, 32'd7, 1));
    send_beat(mk(1, 1, 0, 32'd100));
    send_beat(mk(1, 1, 1, 32'd105));
    send_beat(mk(1, 1, 0, 32'd200));
    send_beat(mk(1, 1, 1, 32'd250));
    send_beat(mk(1, 1, 1, 32'd251, 0, 1));
    send_beat(mk(1, 1, 0, 32'hFFFF_FFF0));
    send_beat(mk(1, 1, 1, 32'h0000_0100));
    send_beat(mk(1, 1, 1, 32'hFFFF_FFFF, 1, 1, 1, 1));
    drain();

    // zero detent setting and long threshold under debounce
    apply_setting(1'b1, 4'd0, 16'd500, 16'd20);
    send_beat(mk(0, 1, 1, 32'd0));
    send_beat(mk(1, 1, 1, 32'd0));
    send_beat(mk(1, 1, 0, 32'd1000));
    send_beat(mk(1, 1, 1, 32'd1300));
    send_beat(mk(1, 1, 0, 32'd2000));
    send_beat(mk(1, 1, 1, 32'd2600, 1, 1, 1, 1));

    run_phase(1'b1, 4'd4, 16'd50, 16'd1000, 0, 0, 300, 1'b1, $urandom());
    run_phase(1'b1, 4'd1, 16'd0, 16'd0, 56, 0, 300, 1'b0, 32'hFFFF_F000);
    run_phase(1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 0, 56, 300, 1'b0, $urandom());
    run_phase(1'b1, 4'd3, 16'd20, 16'd300, 38, 38, 300, 1'b0, $urandom());
    run_phase(1'b0, 4'd7, 16'd100, 16'd50, 0, 0, 60, 1'b0, $urandom());
    run_phase(1'b1, 4'd2, 16'd200, 16'd100, 38, 38, 300, 1'b1, 32'hFFFF_FF00);
    drain();

    if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
      $display("[rotary_encoder_with_button] OK");
    end else begin
      $display("[rotary_encoder_with_button] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[rotary_encoder_with_button] ERROR");
    $finish;
  end

endmodule
